>>> sv/pbx_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pbx_pkg: shared types and constants for the PCR bank
// Transaction payloads, response codes and SHA-1 constants.
// ----------------------------------------------------------------------------
package pbx_pkg;

  typedef struct packed {
    logic        operation;
    logic [7:0]  pcr_sel;
    logic [63:0] extend_hi;
    logic [63:0] extend_mid;
    logic [31:0] extend_lo;
  } in_t;

  typedef struct packed {
    logic        status;
    logic [63:0] value_hi;
    logic [63:0] value_mid;
    logic [31:0] value_lo;
    logic [7:0]  response_tag;
    logic [4:0]  response_length;
  } out_t;

  localparam int unsigned DigestW = 160;
  localparam int unsigned BlockW  = 512;
  localparam int unsigned RoundW  = 7;

  localparam logic OpRead   = 1'b0;
  localparam logic OpExtend = 1'b1;

  localparam logic StatusDone  = 1'b0;
  localparam logic StatusRange = 1'b1;

  localparam logic [7:0] RespTag = 8'hC4;
  localparam logic [4:0] RespLen = 5'd30;

  // padding word and bit length of the 40-byte message
  localparam logic [31:0] PadWord = 32'h8000_0000;
  localparam logic [31:0] MsgBits = 32'd320;

  localparam logic [31:0] H0 = 32'h6745_2301;
  localparam logic [31:0] H1 = 32'hEFCD_AB89;
  localparam logic [31:0] H2 = 32'h98BA_DCFE;
  localparam logic [31:0] H3 = 32'h1032_5476;
  localparam logic [31:0] H4 = 32'hC3D2_E1F0;

  localparam logic [31:0] K0 = 32'h5A82_7999;
  localparam logic [31:0] K1 = 32'h6ED9_EBA1;
  localparam logic [31:0] K2 = 32'h8F1B_BCDC;
  localparam logic [31:0] K3 = 32'hCA62_C1D6;

  localparam logic [RoundW-1:0] RoundPhase1 = 7'd20;
  localparam logic [RoundW-1:0] RoundPhase2 = 7'd40;
  localparam logic [RoundW-1:0] RoundPhase3 = 7'd60;
  localparam logic [RoundW-1:0] RoundLast   = 7'd79;

endpackage

>>> sv/pbx_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pbx_ram: generic single-port-write, single-port-read RAM
// One write and one registered read per cycle.
// ----------------------------------------------------------------------------
module pbx_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 32
) (
  input  logic                                          clk_i,
  input  logic                                          we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]  waddr_i,
  input  logic [WIDTH-1:0]                              wdata_i,
  input  logic                                          re_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]  raddr_i,
  output logic [WIDTH-1:0]                              rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> sv/pbx_sha1_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pbx_sha1_core: iterative SHA-1 compression
// One round per cycle over a 16-word schedule window, then the final add.
// ----------------------------------------------------------------------------
module pbx_sha1_core (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  logic [pbx_pkg::BlockW-1:0]   block_i,
  output logic                         done_o,
  output logic [pbx_pkg::DigestW-1:0]  digest_o
);

  typedef enum logic [1:0] {
    CoreIdle,
    CoreRound,
    CoreFinal
  } core_state_e;

  core_state_e                   state_q;
  logic [pbx_pkg::RoundW-1:0]    cnt_q;
  logic [15:0][31:0]             win_q;
  logic [31:0]                   a_q, b_q, c_q, d_q, e_q;
  logic                          done_q;
  logic [pbx_pkg::DigestW-1:0]   digest_q;

  logic [31:0] f_w, k_w, t_w, sched_w, mix_w;

  always_comb begin
    priority if (cnt_q < pbx_pkg::RoundPhase1) begin
      f_w = (b_q & c_q) | (~b_q & d_q);
      k_w = pbx_pkg::K0;
    end else if (cnt_q < pbx_pkg::RoundPhase2) begin
      f_w = b_q ^ c_q ^ d_q;
      k_w = pbx_pkg::K1;
    end else if (cnt_q < pbx_pkg::RoundPhase3) begin
      f_w = (b_q & c_q) | (b_q & d_q) | (c_q & d_q);
      k_w = pbx_pkg::K2;
    end else begin
      f_w = b_q ^ c_q ^ d_q;
      k_w = pbx_pkg::K3;
    end
  end

  assign t_w     = {a_q[26:0], a_q[31:27]} + f_w + e_q + k_w + win_q[0];
  assign mix_w   = win_q[13] ^ win_q[8] ^ win_q[2] ^ win_q[0];
  assign sched_w = {mix_w[30:0], mix_w[31]};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= CoreIdle;
      cnt_q   <= '0;
      done_q  <= 1'b0;
    end else begin
      done_q <= 1'b0;
      unique case (state_q)
        CoreIdle: begin
          if (start_i) begin
            for (int j = 0; j < 16; j++) begin
              win_q[j] <= block_i[pbx_pkg::BlockW-1-32*j -: 32];
            end
            a_q     <= pbx_pkg::H0;
            b_q     <= pbx_pkg::H1;
            c_q     <= pbx_pkg::H2;
            d_q     <= pbx_pkg::H3;
            e_q     <= pbx_pkg::H4;
            cnt_q   <= '0;
            state_q <= CoreRound;
          end
        end
        CoreRound: begin
          for (int j = 0; j < 15; j++) begin
            win_q[j] <= win_q[j+1];
          end
          win_q[15] <= sched_w;
          a_q <= t_w;
          b_q <= a_q;
          c_q <= {b_q[1:0], b_q[31:2]};
          d_q <= c_q;
          e_q <= d_q;
          cnt_q <= cnt_q + 1'b1;
          if (cnt_q == pbx_pkg::RoundLast) begin
            state_q <= CoreFinal;
          end
        end
        CoreFinal: begin
          digest_q <= {a_q + pbx_pkg::H0, b_q + pbx_pkg::H1, c_q + pbx_pkg::H2,
                       d_q + pbx_pkg::H3, e_q + pbx_pkg::H4};
          done_q   <= 1'b1;
          state_q  <= CoreIdle;
        end
        default: begin
          state_q <= CoreIdle;
        end
      endcase
    end
  end

  assign done_o   = done_q;
  assign digest_o = digest_q;

endmodule

>>> sv/pcr_bank_extend_read.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcr_bank_extend_read: PCR bank with SHA-1 extend and read
// A read takes a registered RAM read, then the response; an extend reads,
// loads, runs 80 SHA-1 rounds in the compression unit, then adds and writes.
// Out-of-range indexes skip the RAM. One transaction at a time: the next is
// accepted the cycle after the result leaves.
// Reset clears control state and the register valid flags; every PCR reads as
// zero until first extended.
// ----------------------------------------------------------------------------
module pcr_bank_extend_read #(
  parameter int unsigned NUM_REGISTERS = 24
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  pbx_pkg::in_t    in_data_i,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output pbx_pkg::out_t   out_data_o
);

  localparam int unsigned AddrW = (NUM_REGISTERS > 1) ? $clog2(NUM_REGISTERS) : 1;

  typedef enum logic [1:0] {
    StIdle,
    StRead,
    StHash,
    StResp
  } state_e;

  state_e                        state_q;
  logic                          op_q;
  logic [AddrW-1:0]              addr_q;
  logic [pbx_pkg::DigestW-1:0]   ext_q;
  logic                          row_ok_q;
  logic [NUM_REGISTERS-1:0]      valid_q;
  pbx_pkg::out_t                 out_q;

  logic                          accept_w;
  logic                          idx_ok_w;
  logic [AddrW-1:0]              in_addr_w;
  logic [pbx_pkg::DigestW-1:0]   rdata_w;
  logic [pbx_pkg::DigestW-1:0]   value_w;
  logic [pbx_pkg::BlockW-1:0]    block_w;
  logic                          start_w;
  logic                          core_done_w;
  logic [pbx_pkg::DigestW-1:0]   digest_w;

  assign in_ready_o = (state_q == StIdle);
  assign accept_w   = in_valid_i && in_ready_o;
  assign idx_ok_w   = in_data_i.pcr_sel < 8'(NUM_REGISTERS);
  assign in_addr_w  = in_data_i.pcr_sel[AddrW-1:0];
  assign value_w    = row_ok_q ? rdata_w : '0;
  assign block_w    = {value_w, ext_q, pbx_pkg::PadWord, 128'd0, pbx_pkg::MsgBits};
  assign start_w    = (state_q == StRead) && (op_q == pbx_pkg::OpExtend);

  pbx_ram #(
    .WIDTH (pbx_pkg::DigestW),
    .DEPTH (NUM_REGISTERS)
  ) u_bank (
    .clk_i   (clk_i),
    .we_i    (core_done_w),
    .waddr_i (addr_q),
    .wdata_i (digest_w),
    .re_i    (accept_w && idx_ok_w),
    .raddr_i (in_addr_w),
    .rdata_o (rdata_w)
  );

  pbx_sha1_core u_sha1 (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (start_w),
    .block_i  (block_w),
    .done_o   (core_done_w),
    .digest_o (digest_w)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= StIdle;
      valid_q  <= '0;
      row_ok_q <= 1'b0;
    end else begin
      unique case (state_q)
        StIdle: begin
          if (accept_w) begin
            op_q   <= in_data_i.operation;
            addr_q <= in_addr_w;
            ext_q  <= {in_data_i.extend_hi, in_data_i.extend_mid, in_data_i.extend_lo};
            if (idx_ok_w) begin
              row_ok_q <= valid_q[in_addr_w];
              state_q  <= StRead;
            end else begin
              out_q   <= '{status: pbx_pkg::StatusRange, value_hi: '0, value_mid: '0,
                           value_lo: '0, response_tag: '0, response_length: '0};
              state_q <= StResp;
            end
          end
        end
        StRead: begin
          if (op_q == pbx_pkg::OpExtend) begin
            state_q <= StHash;
          end else begin
            out_q   <= '{status: pbx_pkg::StatusDone, value_hi: value_w[159:96],
                         value_mid: value_w[95:32], value_lo: value_w[31:0],
                         response_tag: pbx_pkg::RespTag,
                         response_length: pbx_pkg::RespLen};
            state_q <= StResp;
          end
        end
        StHash: begin
          if (core_done_w) begin
            valid_q[addr_q] <= 1'b1;
            out_q   <= '{status: pbx_pkg::StatusDone, value_hi: digest_w[159:96],
                         value_mid: digest_w[95:32], value_lo: digest_w[31:0],
                         response_tag: pbx_pkg::RespTag,
                         response_length: pbx_pkg::RespLen};
            state_q <= StResp;
          end
        end
        StResp: begin
          if (out_ready_i) begin
            state_q <= StIdle;
          end
        end
        default: begin
          state_q <= StIdle;
        end
      endcase
    end
  end

  assign out_valid_o = (state_q == StResp);
  assign out_data_o  = out_q;

endmodule

>>> verif/pcr_bank_extend_read_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcr_bank_extend_read_tb: self-checking bench for the PCR bank
// Drives read and extend transactions, including out-of-range indexes, and
// holds its own copy of the PCR bank with a SHA-1 extend computed here. Each
// response is compared field by field with the oldest predicted one. The
// bench applies random idling on both sides, a long receiver hold-off, a
// full drain and a burst with no idling.
// ----------------------------------------------------------------------------
module pcr_bank_extend_read_tb;

  localparam int unsigned NumPcr      = 24;
  localparam int unsigned HoldCycles  = 600;
  localparam int unsigned DrainCycles = 120;
  localparam int unsigned CycleLimit  = 1_000_000;

  logic          clk = 1'b0;
  logic          rst_n = 1'b0;
  logic          in_valid = 1'b0;
  logic          in_ready;
  pbx_pkg::in_t  in_data = '0;
  logic          out_valid;
  logic          out_ready = 1'b0;
  pbx_pkg::out_t out_data;

  logic [159:0]  pcr_shadow [NumPcr];
  pbx_pkg::out_t expected_rsp_q [$];
  int unsigned   err_cnt = 0;
  int unsigned   cycle_cnt = 0;
  bit            idle_en = 1'b1;

  logic        hold_req = 1'b0;
  logic        hold_ack = 1'b0;
  int unsigned hold_left = 0;

  pcr_bank_extend_read #(
    .NUM_REGISTERS(NumPcr)
  ) u_top (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready),
    .in_data_i  (in_data),
    .out_valid_o(out_valid),
    .out_ready_i(out_ready),
    .out_data_o (out_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CycleLimit) begin
      $display("pcr_bank_extend_read: mismatch");
      $finish;
    end
  end

  // SHA-1 of old value || supplied digest, a 40-byte message padded to a single 64-byte block
  function automatic logic [159:0] sha1_extend_digest(input logic [159:0] old_val,
                                                       input logic [159:0] digest);
    logic [511:0] msg;
    logic [31:0]  w [80];
    logic [31:0]  a, b, c, d, e, f, k, t, x;
    msg = {old_val, digest, pbx_pkg::PadWord, 128'h0, pbx_pkg::MsgBits};
    for (int i = 0; i < 16; i++) w[i] = msg[511-32*i -: 32];
    for (int i = 16; i < 80; i++) begin
      x = w[i-3] ^ w[i-8] ^ w[i-14] ^ w[i-16];
      w[i] = {x[30:0], x[31]};
    end
    a = pbx_pkg::H0; b = pbx_pkg::H1; c = pbx_pkg::H2; d = pbx_pkg::H3; e = pbx_pkg::H4;
    for (int i = 0; i < 80; i++) begin
      if (i < 20) begin
        f = (b & c) | (~b & d);
        k = pbx_pkg::K0;
      end else if (i < 40) begin
        f = b ^ c ^ d;
        k = pbx_pkg::K1;
      end else if (i < 60) begin
        f = (b & c) | (b & d) | (c & d);
        k = pbx_pkg::K2;
      end else begin
        f = b ^ c ^ d;
        k = pbx_pkg::K3;
      end
      t = {a[26:0], a[31:27]} + f + e + k + w[i];
      e = d;
      d = c;
      c = {b[1:0], b[31:2]};
      b = a;
      a = t;
    end
    return {pbx_pkg::H0 + a, pbx_pkg::H1 + b, pbx_pkg::H2 + c,
            pbx_pkg::H3 + d, pbx_pkg::H4 + e};
  endfunction

  function automatic pbx_pkg::out_t predict_pcr_response(input pbx_pkg::in_t cmd);
    pbx_pkg::out_t rsp;
    logic [159:0]  val;
    logic [4:0]    sel;
    rsp = '0;
    if (cmd.pcr_sel >= NumPcr) begin
      rsp.status = pbx_pkg::StatusRange;
      return rsp;
    end
    sel = cmd.pcr_sel[4:0];
    if (cmd.operation == pbx_pkg::OpExtend)
      pcr_shadow[sel] = sha1_extend_digest(pcr_shadow[sel],
          {cmd.extend_hi, cmd.extend_mid, cmd.extend_lo});
    val = pcr_shadow[sel];
    rsp.status          = pbx_pkg::StatusDone;
    rsp.value_hi        = val[159:96];
    rsp.value_mid       = val[95:32];
    rsp.value_lo        = val[31:0];
    rsp.response_tag    = pbx_pkg::RespTag;
    rsp.response_length = pbx_pkg::RespLen;
    return rsp;
  endfunction

  function automatic pbx_pkg::in_t mk_cmd(input logic op, input logic [7:0] idx,
                                          input logic [159:0] digest);
    pbx_pkg::in_t cmd;
    cmd.operation  = op;
    cmd.pcr_sel    = idx;
    cmd.extend_hi  = digest[159:96];
    cmd.extend_mid = digest[95:32];
    cmd.extend_lo  = digest[31:0];
    return cmd;
  endfunction

  function automatic pbx_pkg::in_t rand_cmd();
    logic [7:0] idx;
    if ($urandom_range(0, 99) < 85) idx = 8'($urandom_range(0, NumPcr - 1));
    else idx = 8'($urandom_range(NumPcr, 255));
    return mk_cmd($urandom_range(0, 1) ? pbx_pkg::OpExtend : pbx_pkg::OpRead, idx,
                  {$urandom, $urandom, $urandom, $urandom, $urandom});
  endfunction

  task automatic report_mismatch(input string field, input logic [63:0] got,
                                 input logic [63:0] exp);
    $display("ERROR @%0t: %s got %h, expected %h", $time, field, got, exp);
    err_cnt++;
  endtask

  // one transaction on the request channel; valid stays up for a back-to-back one
  task automatic send_cmd(input pbx_pkg::in_t cmd);
    if (idle_en && $urandom_range(0, 99) < 19) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= cmd;
    do @(posedge clk); while (!in_ready);
    expected_rsp_q.push_back(predict_pcr_response(cmd));
  endtask

  task automatic wait_for_drain();
    in_valid <= 1'b0;
    while (expected_rsp_q.size() != 0) @(posedge clk);
  endtask

  // receiver hold-off counter
  always @(posedge clk) begin
    if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end else if (hold_req != hold_ack) begin
      hold_ack  <= hold_req;
      hold_left <= HoldCycles;
    end
  end

  always @(posedge clk) begin
    out_ready <= (hold_left == 0) && (hold_req == hold_ack) &&
                 !(idle_en && $urandom_range(0, 99) < 19);
  end

  always @(posedge clk) begin
    pbx_pkg::out_t exp;
    if (rst_n && out_valid && out_ready) begin
      if (expected_rsp_q.size() == 0) begin
        report_mismatch("unexpected response, status", 64'(out_data.status), 64'(0));
      end else begin
        exp = expected_rsp_q.pop_front();
        if (out_data.status !== exp.status)
          report_mismatch("status", 64'(out_data.status), 64'(exp.status));
        if (out_data.value_hi !== exp.value_hi)
          report_mismatch("value_hi", out_data.value_hi, exp.value_hi);
        if (out_data.value_mid !== exp.value_mid)
          report_mismatch("value_mid", out_data.value_mid, exp.value_mid);
        if (out_data.value_lo !== exp.value_lo)
          report_mismatch("value_lo", 64'(out_data.value_lo), 64'(exp.value_lo));
        if (out_data.response_tag !== exp.response_tag)
          report_mismatch("response_tag", 64'(out_data.response_tag),
                          64'(exp.response_tag));
        if (out_data.response_length !== exp.response_length)
          report_mismatch("response_length", 64'(out_data.response_length),
                          64'(exp.response_length));
      end
    end
  end

  task automatic test_directed();
    logic [159:0] ones;
    ones = '1;
    send_cmd(mk_cmd(pbx_pkg::OpRead, 8'd0, '0));
    send_cmd(mk_cmd(pbx_pkg::OpRead, 8'(NumPcr - 1), ones));
    send_cmd(mk_cmd(pbx_pkg::OpExtend, 8'd0, '0));
    send_cmd(mk_cmd(pbx_pkg::OpRead, 8'd0, ones));
    send_cmd(mk_cmd(pbx_pkg::OpExtend, 8'd0, ones));
    send_cmd(mk_cmd(pbx_pkg::OpExtend, 8'(NumPcr - 1), ones));
    send_cmd(mk_cmd(pbx_pkg::OpRead, 8'(NumPcr - 1), '0));
    send_cmd(mk_cmd(pbx_pkg::OpRead, 8'(NumPcr), '0));
    send_cmd(mk_cmd(pbx_pkg::OpExtend, 8'(NumPcr), ones));
    send_cmd(mk_cmd(pbx_pkg::OpExtend, 8'd255, ones));
    send_cmd(mk_cmd(pbx_pkg::OpRead, 8'd255, ones));
    send_cmd(mk_cmd(pbx_pkg::OpRead, 8'd128, '0));
    send_cmd(mk_cmd(pbx_pkg::OpExtend, 8'd31, '0));
    send_cmd(mk_cmd(pbx_pkg::OpRead, 8'(NumPcr - 1), ones));
    send_cmd(mk_cmd(pbx_pkg::OpExtend, 8'd1, {5{32'hA5A5_5A5A}}));
    send_cmd(mk_cmd(pbx_pkg::OpExtend, 8'd1, {5{32'h5A5A_A5A5}}));
    send_cmd(mk_cmd(pbx_pkg::OpRead, 8'd1, {5{$urandom}}));
    send_cmd(mk_cmd(pbx_pkg::OpRead, 8'd0, '0));
    send_cmd(mk_cmd(pbx_pkg::OpRead, 8'd2, '0));
    wait_for_drain();
  endtask

  task automatic test_receiver_hold();
    hold_req <= ~hold_req;
    repeat (8) send_cmd(rand_cmd());
    wait_for_drain();
  endtask

  task automatic test_random_traffic(input int unsigned n);
    repeat (n) send_cmd(rand_cmd());
  endtask

  task automatic test_burst_traffic(input int unsigned n);
    idle_en = 1'b0;
    repeat (n) send_cmd(rand_cmd());
    wait_for_drain();
    idle_en = 1'b1;
  endtask

  initial begin
    for (int i = 0; i < NumPcr; i++) pcr_shadow[i] = '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_receiver_hold();
    test_random_traffic(500);
    test_burst_traffic(300);
    test_random_traffic(320);
    wait_for_drain();
    repeat (DrainCycles) @(posedge clk);
    if (err_cnt == 0) begin
      $display("pcr_bank_extend_read: match");
    end else begin
      $display("pcr_bank_extend_read: mismatch");
    end
    $finish;
  end

endmodule
